// ===== src/ptt_pkg.sv =====
// Package for the periodic task timer table: payload structs, table size, mode and status codes.
// No dependencies.
`timescale 1ns / 1ps
package ptt_pkg;
  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  task_tag;
    logic [31:0] delay_ms;
    logic [31:0] period_ms;
    logic [3:0]  slot;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] out_slot;
    logic [7:0] out_tag;
    logic       last;
  } rsp_t;

  localparam logic [2:0] MODE_TICK  = 3'd0;
  localparam logic [2:0] MODE_ADD   = 3'd1;
  localparam logic [2:0] MODE_DEL   = 3'd2;
  localparam logic [2:0] MODE_DISP  = 3'd3;
  localparam logic [2:0] MODE_CLEAR = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;
  localparam logic [1:0] ST_NONE  = 2'd3;

  localparam int MAX_TASKS = 16;
  localparam int unsigned RESULT_LIMIT = 16;
endpackage

// ===== src/periodic_task_timer_table.sv =====
// Periodic task timer table: top level with entry registers, sequencer and serial divider.
// Depends on ptt_pkg.
//
//   channel | direction | handshake          | payload
//   cmd     | in        | cmd_valid/cmd_ready | ptt_pkg::cmd_t
//   rsp     | out       | rsp_valid/rsp_ready | ptt_pkg::rsp_t
//   cfg     | in        | cfg_we              | cfg_data (tick_length)
//
// Tick and clear visit one entry per cycle and then present a single result word.
// Add runs two 32-step restoring divides on one shared divider, then writes the entry.
// Delete shifts the entries above the slot down, one per cycle.
// Dispatch visits one entry per cycle, shifts after each one-shot removal and holds
// while a word waits on rsp_ready.
// Reset clears the table and sets tick_length to 10; cmd_ready is low while busy
// or while a result word waits.
`timescale 1ns / 1ps
module periodic_task_timer_table (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  ptt_pkg::cmd_t    cmd,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output ptt_pkg::rsp_t    rsp,
  input  logic             cfg_we,
  input  logic [9:0]       cfg_data
);
  import ptt_pkg::*;

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int RW = $clog2(RESULT_LIMIT + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_TICK, S_DIVD, S_DIVP, S_ADDW, S_DISP, S_SHIFT, S_CLEAR, S_OUT
  } state_t;

  state_t state;
  logic [9:0] tick_length;
  logic           ev [MAX_TASKS];
  logic [7:0]     et [MAX_TASKS];
  logic [31:0]    ed [MAX_TASKS];
  logic [31:0]    ep [MAX_TASKS];
  logic [7:0]     er [MAX_TASKS];
  logic [CW-1:0]  task_count;

  cmd_t        cur;
  logic [IW-1:0] idx;     // walk pointer
  logic [IW-1:0] sidx;    // shift pointer
  logic [RW-1:0] n_out;
  state_t        shift_ret; // where to go once the shift is done
  logic [31:0] quo, rem_d, dly_q;
  logic [5:0]  bitc;
  logic [9:0]  dvs;
  logic [IW-1:0] free_idx;
  logic          free_ok;
  logic          disp_more;

  // first free slot = task_count (table is compacted)
  always_comb begin
    free_ok  = task_count < CW'(MAX_TASKS);
    free_idx = task_count[IW-1:0];
  end

  // one restoring divide step
  logic [32:0] rem_sh;
  logic        ge;
  always_comb begin
    rem_sh = {rem_d, quo[31]};
    ge     = rem_sh >= {23'd0, dvs};
  end

  // lookahead: another ready entry above idx, still within the result limit
  always_comb begin
    disp_more = 1'b0;
    for (int k = 0; k < MAX_TASKS; k++)
      if (IW'(k) > idx && ev[k] && er[k] != 8'd0) disp_more = 1'b1;
    if (n_out + 1'b1 >= RW'(RESULT_LIMIT)) disp_more = 1'b0;
  end

  assign cmd_ready = (state == S_IDLE) && !rsp_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tick_length <= 10'd10;
      task_count <= '0;
      rsp_valid <= 1'b0;
      for (int k = 0; k < MAX_TASKS; k++) begin
        ev[k] <= 1'b0; et[k] <= '0; ed[k] <= '0; ep[k] <= '0; er[k] <= '0;
      end
    end else begin
      if (cfg_we) tick_length <= cfg_data;
      unique case (state)
        S_IDLE: begin
          if (rsp_valid) begin
            if (rsp_ready) rsp_valid <= 1'b0;
          end else if (cmd_valid) begin
            cur <= cmd;
            idx <= '0;
            n_out <= '0;
            unique case (cmd.mode)
              MODE_TICK: state <= S_TICK;
              MODE_ADD: begin
                if (!free_ok) begin
                  rsp <= '{ST_FULL, 4'd0, 8'd0, 1'b1};
                  state <= S_OUT;
                end else begin
                  dvs <= (tick_length == 10'd0) ? 10'd1 : tick_length;
                  quo <= cmd.delay_ms; rem_d <= '0; bitc <= '0;
                  state <= S_DIVD;
                end
              end
              MODE_DEL: begin
                if ({28'd0, cmd.slot} >= 32'(MAX_TASKS) || !ev[cmd.slot[IW-1:0]]) begin
                  rsp <= '{ST_BAD, cmd.slot, 8'd0, 1'b1};
                  state <= S_OUT;
                end else begin
                  rsp <= '{ST_OK, cmd.slot, 8'd0, 1'b1};
                  sidx <= cmd.slot[IW-1:0];
                  shift_ret <= S_OUT;
                  state <= S_SHIFT;
                end
              end
              MODE_DISP: state <= S_DISP;
              MODE_CLEAR: state <= S_CLEAR;
              default: begin
                rsp <= '{ST_OK, 4'd0, 8'd0, 1'b1};
                state <= S_OUT;
              end
            endcase
          end
        end
        S_TICK: begin
          if (ev[idx]) begin
            if (ed[idx] == 32'd0) begin
              if (er[idx] != 8'hFF) er[idx] <= er[idx] + 8'd1;
              if (ep[idx] != 32'd0) ed[idx] <= ep[idx];
            end else ed[idx] <= ed[idx] - 32'd1;
          end
          if (idx == IW'(MAX_TASKS - 1)) begin
            rsp <= '{ST_OK, 4'd0, 8'd0, 1'b1};
            state <= S_OUT;
          end else idx <= idx + 1'b1;
        end
        S_DIVD, S_DIVP: begin
          if (bitc == 6'd31) begin
            bitc <= '0;
            if (state == S_DIVD) begin
              dly_q <= {quo[30:0], ge};
              quo <= cur.period_ms; rem_d <= '0;
              state <= S_DIVP;
            end else begin
              quo <= {quo[30:0], ge};
              state <= S_ADDW;
            end
          end else begin
            rem_d <= ge ? 32'(rem_sh - {23'd0, dvs}) : rem_sh[31:0];
            quo   <= {quo[30:0], ge};
            bitc  <= bitc + 6'd1;
          end
        end
        S_ADDW: begin
          ev[free_idx] <= 1'b1;
          et[free_idx] <= cur.task_tag;
          ed[free_idx] <= dly_q;
          ep[free_idx] <= quo;
          er[free_idx] <= 8'd0;
          task_count <= task_count + 1'b1;
          rsp <= '{ST_OK, 4'(free_idx), 8'd0, 1'b1};
          state <= S_OUT;
        end
        S_DISP: begin
          // hold while the previous word waits
          if (!rsp_valid || rsp_ready) begin
            if (ev[idx] && er[idx] != 8'd0 && n_out < RW'(RESULT_LIMIT)) begin
              rsp <= '{ST_OK, 4'(idx), et[idx], !disp_more};
              rsp_valid <= 1'b1;
              n_out <= n_out + 1'b1;
              er[idx] <= er[idx] - 8'd1;
              if (ep[idx] == 32'd0) begin
                sidx <= idx;
                shift_ret <= disp_more ? S_DISP : S_IDLE;
                state <= S_SHIFT;
              end else if (!disp_more) state <= S_IDLE;
              else idx <= idx + 1'b1;
            end else if (idx == IW'(MAX_TASKS - 1)) begin
              if (n_out == '0) begin
                rsp <= '{ST_NONE, 4'd0, 8'd0, 1'b1};
                rsp_valid <= 1'b1;
              end else rsp_valid <= 1'b0;
              state <= S_IDLE;
            end else begin
              rsp_valid <= 1'b0;
              idx <= idx + 1'b1;
            end
          end
        end
        S_SHIFT: begin
          if (rsp_ready) rsp_valid <= 1'b0;
          if (sidx == IW'(MAX_TASKS - 1)) begin
            ev[sidx] <= 1'b0; et[sidx] <= '0; ed[sidx] <= '0;
            ep[sidx] <= '0; er[sidx] <= '0;
            if (task_count != '0) task_count <= task_count - 1'b1;
            state <= shift_ret;
          end else begin
            ev[sidx] <= ev[sidx + 1'b1]; et[sidx] <= et[sidx + 1'b1];
            ed[sidx] <= ed[sidx + 1'b1]; ep[sidx] <= ep[sidx + 1'b1];
            er[sidx] <= er[sidx + 1'b1];
            sidx <= sidx + 1'b1;
          end
        end
        S_CLEAR: begin
          ev[idx] <= 1'b0; et[idx] <= '0; ed[idx] <= '0; ep[idx] <= '0; er[idx] <= '0;
          if (idx == IW'(MAX_TASKS - 1)) begin
            task_count <= '0;
            rsp <= '{ST_OK, 4'd0, 8'd0, 1'b1};
            state <= S_OUT;
          end else idx <= idx + 1'b1;
        end
        S_OUT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    task_count <= CW'(MAX_TASKS)) else $error("task count overflow");
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("word changed while stalled");
endmodule
